// ===== src/mqfst_pkg.sv =====
// ----------------------------------------------------------------------------
// mqfst_pkg: shared types and codes for the QoS flow state table
// Flow state codes, event codes, table entry layout and the control and
// status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package mqfst_pkg;

	// flow states
	localparam logic [3:0] ST_NULL            = 4'd0;
	localparam logic [3:0] ST_PUBLISH_SEND    = 4'd1;
	localparam logic [3:0] ST_PUBACK_SEND     = 4'd2;
	localparam logic [3:0] ST_PUBACK_PENDING  = 4'd3;
	localparam logic [3:0] ST_PUBREC_SEND     = 4'd4;
	localparam logic [3:0] ST_PUBREC_PENDING  = 4'd5;
	localparam logic [3:0] ST_PUBREL_SEND     = 4'd6;
	localparam logic [3:0] ST_PUBREL_PENDING  = 4'd7;
	localparam logic [3:0] ST_PUBCOMP_SEND    = 4'd8;
	localparam logic [3:0] ST_PUBCOMP_PENDING = 4'd9;
	localparam logic [3:0] ST_DONE            = 4'd10;

	// event kinds
	localparam logic [1:0] KIND_RESERVE = 2'd0;
	localparam logic [1:0] KIND_PUBLISH = 2'd1;
	localparam logic [1:0] KIND_ACK     = 2'd2;

	// ack types
	localparam logic [1:0] ACK_PUBACK  = 2'd0;
	localparam logic [1:0] ACK_PUBREC  = 2'd1;
	localparam logic [1:0] ACK_PUBREL  = 2'd2;
	localparam logic [1:0] ACK_PUBCOMP = 2'd3;

	localparam logic [1:0] QOS_1 = 2'd1;
	localparam logic [1:0] QOS_2 = 2'd2;

	localparam logic [15:0] ID_NONE = 16'd0;

	typedef struct packed {
		logic [15:0] id;
		logic [1:0]  qos;
		logic [3:0]  st;
	} entry_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [15:0] packet_id;
		logic [1:0]  qos;
		logic        direction;
		logic [1:0]  ack_type;
	} item_t;

	typedef struct packed {
		logic start;    // latch item, rewind scan
		logic scan_en;  // issue one table read
		logic commit;   // write table, load result
	} cmd_t;

	typedef struct packed {
		logic scan_last; // read of last slot being issued
		logic out_free;  // result register can take a value
	} status_t;

	// legal ack transitions
	function automatic logic ack_ok(input logic [3:0] cur, input logic [3:0] nxt);
		logic ok;
		unique case (cur)
			ST_PUBACK_SEND, ST_PUBACK_PENDING,
			ST_PUBCOMP_SEND, ST_PUBCOMP_PENDING: ok = (nxt == ST_DONE);
			ST_PUBREC_SEND:    ok = (nxt == ST_PUBREL_PENDING);
			ST_PUBREL_PENDING: ok = (nxt == ST_PUBCOMP_SEND);
			ST_PUBREC_PENDING: ok = (nxt == ST_PUBREL_SEND);
			ST_PUBREL_SEND:    ok = (nxt == ST_PUBCOMP_PENDING);
			default:           ok = 1'b0;
		endcase
		return ok;
	endfunction

endpackage

// ===== src/mqfst_ctrl.sv =====
// ----------------------------------------------------------------------------
// mqfst_ctrl: event sequencer
// Accepts one event, runs the table scan, then commits the result once the
// output register is free.
// ----------------------------------------------------------------------------
module mqfst_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  mqfst_pkg::status_t sts,
	output mqfst_pkg::cmd_t    cmd
);

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_SCAN  = 2'd1;
	localparam logic [1:0] S_DRAIN = 2'd2;
	localparam logic [1:0] S_WRITE = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		state_d     = state_q;
		cmd.start   = 1'b0;
		cmd.scan_en = 1'b0;
		cmd.commit  = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.start = 1'b1;
					state_d   = S_SCAN;
				end
			end
			S_SCAN: begin
				cmd.scan_en = 1'b1;
				if (sts.scan_last) state_d = S_DRAIN;
			end
			S_DRAIN: state_d = S_WRITE;
			S_WRITE: begin
				if (sts.out_free) begin
					cmd.commit = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else         state_q <= state_d;
	end

endmodule

// ===== src/mqfst_dp.sv =====
// ----------------------------------------------------------------------------
// mqfst_dp: table storage, scan and decision datapath
// Two entry memories with per-slot valid bits, a slot scan that finds the
// matching id and the lowest free slot, the event decision and the result
// register.
// ----------------------------------------------------------------------------
module mqfst_dp #(
	parameter int TABLE_DEPTH = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  mqfst_pkg::cmd_t    cmd,
	output mqfst_pkg::status_t sts,
	input  mqfst_pkg::item_t   item,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [3:0]         out_state
);

	localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam logic [IW-1:0] LAST_SLOT = IW'(TABLE_DEPTH - 1);

	mqfst_pkg::entry_t mem_out [TABLE_DEPTH];
	mqfst_pkg::entry_t mem_in  [TABLE_DEPTH];
	logic [TABLE_DEPTH-1:0] vo_q, vi_q;

	mqfst_pkg::item_t  item_q;
	logic              tsel_q;   // 1: outgoing table
	logic              tsel_d;
	logic [IW-1:0]     addr_q;

	mqfst_pkg::entry_t rd_out_s1, rd_in_s1, ent_s1;
	logic              vld_s1, rv_s1;
	logic [IW-1:0]     idx_s1;

	logic              match_q, free_q;
	logic [IW-1:0]     mslot_q, fslot_q;
	logic [1:0]        mqos_q;
	logic [3:0]        mst_q;

	logic              m_valid_q;
	logic [3:0]        m_state_q;

	logic [3:0]        res;
	logic              wr_en, set_v, clr_v;
	logic [IW-1:0]     wr_slot;
	mqfst_pkg::entry_t wr_ent;
	logic [3:0]        nxt;
	logic [1:0]        need_qos;

	// table choice for the incoming event
	always_comb begin
		unique case (item.kind)
			mqfst_pkg::KIND_RESERVE: tsel_d = 1'b1;
			mqfst_pkg::KIND_PUBLISH: tsel_d = !item.direction;
			mqfst_pkg::KIND_ACK:
				tsel_d = (item.ack_type == mqfst_pkg::ACK_PUBREL) ? !item.direction
				                                                  : item.direction;
			default: tsel_d = 1'b0;
		endcase
	end

	assign sts.scan_last = cmd.scan_en && (addr_q == LAST_SLOT);
	assign sts.out_free  = !m_valid_q || out_ready;
	assign ent_s1        = tsel_q ? rd_out_s1 : rd_in_s1;

	// decision
	always_comb begin
		res      = mqfst_pkg::ST_NULL;
		wr_en    = 1'b0;
		set_v    = 1'b0;
		clr_v    = 1'b0;
		wr_slot  = mslot_q;
		wr_ent   = '{id: item_q.packet_id, qos: mqos_q, st: mst_q};
		nxt      = mqfst_pkg::ST_DONE;
		need_qos = mqfst_pkg::QOS_2;
		unique case (item_q.kind)
			mqfst_pkg::KIND_RESERVE: begin
				if (item_q.packet_id != mqfst_pkg::ID_NONE && !match_q && free_q &&
				    (item_q.qos == mqfst_pkg::QOS_1 || item_q.qos == mqfst_pkg::QOS_2)) begin
					res     = mqfst_pkg::ST_PUBLISH_SEND;
					wr_en   = 1'b1;
					set_v   = 1'b1;
					wr_slot = fslot_q;
					wr_ent  = '{id: item_q.packet_id, qos: item_q.qos,
					            st: mqfst_pkg::ST_PUBLISH_SEND};
				end
			end
			mqfst_pkg::KIND_PUBLISH: begin
				if (item_q.packet_id == mqfst_pkg::ID_NONE) begin
					res = mqfst_pkg::ST_DONE;
				end else if (!item_q.direction) begin
					if (match_q && mst_q == mqfst_pkg::ST_PUBLISH_SEND) begin
						if (mqos_q == mqfst_pkg::QOS_1)      res = mqfst_pkg::ST_PUBACK_PENDING;
						else if (mqos_q == mqfst_pkg::QOS_2) res = mqfst_pkg::ST_PUBREC_PENDING;
						wr_en     = (res != mqfst_pkg::ST_NULL);
						wr_ent.st = res;
					end
				end else if (!match_q && free_q) begin
					if (item_q.qos == mqfst_pkg::QOS_1)      res = mqfst_pkg::ST_PUBACK_SEND;
					else if (item_q.qos == mqfst_pkg::QOS_2) res = mqfst_pkg::ST_PUBREC_SEND;
					wr_en   = (res != mqfst_pkg::ST_NULL);
					set_v   = wr_en;
					wr_slot = fslot_q;
					wr_ent  = '{id: item_q.packet_id, qos: item_q.qos, st: res};
				end
			end
			mqfst_pkg::KIND_ACK: begin
				unique case (item_q.ack_type)
					mqfst_pkg::ACK_PUBACK: begin
						need_qos = mqfst_pkg::QOS_1;
						nxt      = mqfst_pkg::ST_DONE;
					end
					mqfst_pkg::ACK_PUBREC: nxt = item_q.direction ? mqfst_pkg::ST_PUBREL_SEND
					                                              : mqfst_pkg::ST_PUBREL_PENDING;
					mqfst_pkg::ACK_PUBREL: nxt = item_q.direction ? mqfst_pkg::ST_PUBCOMP_SEND
					                                              : mqfst_pkg::ST_PUBCOMP_PENDING;
					default: nxt = mqfst_pkg::ST_DONE;
				endcase
				if (match_q && mqos_q == need_qos && mqfst_pkg::ack_ok(mst_q, nxt)) begin
					res       = nxt;
					clr_v     = (nxt == mqfst_pkg::ST_DONE);
					wr_en     = !clr_v;
					wr_ent.st = nxt;
				end
			end
			default: res = mqfst_pkg::ST_NULL;
		endcase
	end

	// memories: registered read during scan, write on commit
	always_ff @(posedge clk) begin
		if (cmd.scan_en) begin
			rd_out_s1 <= mem_out[addr_q];
			rd_in_s1  <= mem_in[addr_q];
		end
		if (cmd.commit && wr_en) begin
			if (tsel_q) mem_out[wr_slot] <= wr_ent;
			else        mem_in[wr_slot]  <= wr_ent;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) item_q <= item;
		if (cmd.commit) m_state_q <= res;
		if (vld_s1 && rv_s1 && !match_q && ent_s1.id == item_q.packet_id) begin
			mslot_q <= idx_s1;
			mqos_q  <= ent_s1.qos;
			mst_q   <= ent_s1.st;
		end
		if (vld_s1 && !rv_s1 && !free_q) fslot_q <= idx_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vo_q      <= '0;
			vi_q      <= '0;
			tsel_q    <= 1'b0;
			addr_q    <= '0;
			vld_s1    <= 1'b0;
			rv_s1     <= 1'b0;
			idx_s1    <= '0;
			match_q   <= 1'b0;
			free_q    <= 1'b0;
			m_valid_q <= 1'b0;
		end else begin
			vld_s1 <= cmd.scan_en;
			if (cmd.scan_en) begin
				rv_s1  <= tsel_q ? vo_q[addr_q] : vi_q[addr_q];
				idx_s1 <= addr_q;
				addr_q <= addr_q + 1'b1;
			end
			if (cmd.start) begin
				tsel_q  <= tsel_d;
				addr_q  <= '0;
				match_q <= 1'b0;
				free_q  <= 1'b0;
			end else if (vld_s1) begin
				if (rv_s1 && ent_s1.id == item_q.packet_id) match_q <= 1'b1;
				if (!rv_s1) free_q <= 1'b1;
			end
			if (cmd.commit && (set_v || clr_v)) begin
				if (tsel_q) vo_q[wr_slot] <= set_v;
				else        vi_q[wr_slot] <= set_v;
			end
			if (cmd.commit)             m_valid_q <= 1'b1;
			else if (out_ready)         m_valid_q <= 1'b0;
		end
	end

	assign out_valid = m_valid_q;
	assign out_state = m_state_q;

	// a commit never overwrites a result that is still waiting
	a_commit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> (!m_valid_q || out_ready))
		else $error("result overwritten");

	// a committed result is presented next cycle
	a_commit_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> m_valid_q)
		else $error("result lost");

	// an insert goes to an empty slot
	a_insert_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.commit && set_v) |-> !(tsel_q ? vo_q[wr_slot] : vi_q[wr_slot]))
		else $error("insert into occupied slot");

	// publish_send comes only from a reserve
	a_reserve_only: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.commit && res == mqfst_pkg::ST_PUBLISH_SEND) |->
		(item_q.kind == mqfst_pkg::KIND_RESERVE && tsel_q))
		else $error("publish_send from non-reserve event");

endmodule

// ===== src/mqtt_qos_flow_state_table.sv =====
// ----------------------------------------------------------------------------
// mqtt_qos_flow_state_table: QoS1/QoS2 publish handshake tracker
// Outgoing and incoming flow tables of TABLE_DEPTH entries with a
// sequenced slot scan per event.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel s_*: one event per transfer. s_tuser carries the kind
//   (reserve, publish, ack); s_tdata carries packet id, qos, direction and
//   ack type. Master channel m_*: exactly one result transfer per event,
//   the new flow state (0 on any failure).
// Sequence / throughput:
//   An event passes from accept to result through a latch step, a scan of
//   the selected table through its single read port (one slot per cycle,
//   registered read), a drain step for the last read and a commit step,
//   which waits for a free output register. s_tready is high only between
//   events, so a new event is not accepted until the last one has committed.
// Reset:
//   arst_n clears every slot's valid bit at once; both tables read empty
//   right after reset with no clearing pass.
// Stall:
//   The result sits in an output register; the next event can be accepted
//   and scanned while it waits. Its commit holds until m_tready frees the
//   register.
// ----------------------------------------------------------------------------
module mqtt_qos_flow_state_table #(
	parameter int TABLE_DEPTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,  // [15:0] packet_id, [17:16] qos, [18] direction,
	                              // [20:19] ack_type, [23:21] zero
	input  logic [1:0]  s_tuser,  // [1:0] kind
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata   // [3:0] new_state, [7:4] zero
);

	mqfst_pkg::cmd_t    cmd;
	mqfst_pkg::status_t sts;
	mqfst_pkg::item_t   item;
	logic [3:0]         new_state;

	// unpack the event
	assign item.kind      = s_tuser;
	assign item.packet_id = s_tdata[15:0];
	assign item.qos       = s_tdata[17:16];
	assign item.direction = s_tdata[18];
	assign item.ack_type  = s_tdata[20:19];

	mqfst_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	mqfst_dp #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.item      (item),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_state (new_state)
	);

	assign m_tdata = {4'b0000, new_state};

endmodule

// ===== tb/mqtt_qos_flow_state_table_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mqtt_qos_flow_state_table_tb: self-checking bench for the QoS flow tables
// Drives reserve, publish and ack events on the slave stream. It keeps a
// shadow copy of both flow tables to predict each new state, and checks
// every result transfer on the master stream against that prediction.
// ----------------------------------------------------------------------------
module mqtt_qos_flow_state_table_tb;

	localparam int TABLE_DEPTH = 16;
	localparam int IDLE_LIMIT  = 2000;  // cycles with no transfer on either side

	// codes local to the bench
	localparam logic [1:0] KIND_UNUSED = 2'd3;
	localparam logic [1:0] QOS_0       = 2'd0;
	localparam logic [1:0] QOS_3       = 2'd3;
	localparam logic       DIR_SENT    = 1'b0;
	localparam logic       DIR_RCVD    = 1'b1;
	localparam int         SIDE_OUT    = 0;
	localparam int         SIDE_IN     = 1;

	typedef struct {
		mqfst_pkg::item_t ev;
		logic [3:0]       new_state;
	} flow_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [23:0] s_tdata = '0;   // [15:0] packet_id, [17:16] qos, [18] direction,
	                             // [20:19] ack_type, [23:21] zero
	logic [1:0]  s_tuser = '0;   // [1:0] kind
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;        // [3:0] new_state, [7:4] zero

	// shadow tables, index 0 outgoing, 1 incoming
	mqfst_pkg::entry_t flows [2][TABLE_DEPTH] = '{default: '0};
	flow_result_t      pending_states [$];

	bit tx_idle = 1'b1;
	bit rx_idle = 1'b1;
	int rx_hold_cycles = 0;
	int n_errors = 0;
	int n_sent = 0;
	int n_results = 0;
	int n_done = 0;
	int n_null = 0;
	int idle_cycles = 0;

	mqtt_qos_flow_state_table #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ---------------------------------------------------------------- predictor

	// slot holding id, -1 if absent; id zero never matches
	function automatic int find_flow(input int side, input logic [15:0] id);
		if (id == mqfst_pkg::ID_NONE)
			return -1;
		for (int i = 0; i < TABLE_DEPTH; i++)
			if (flows[side][i].id == id)
				return i;
		return -1;
	endfunction

	function automatic int free_slot(input int side);
		for (int i = 0; i < TABLE_DEPTH; i++)
			if (flows[side][i].id == mqfst_pkg::ID_NONE)
				return i;
		return -1;
	endfunction

	// applies one event to the shadow tables, returns the new flow state
	function automatic logic [3:0] advance_flows(input mqfst_pkg::item_t ev);
		int side;
		int slot;
		logic [3:0] nxt;
		logic [1:0] want_qos;
		logic legal;
		unique case (ev.kind)
			mqfst_pkg::KIND_RESERVE: begin
				if (ev.packet_id == mqfst_pkg::ID_NONE ||
				    !(ev.qos == mqfst_pkg::QOS_1 || ev.qos == mqfst_pkg::QOS_2))
					return mqfst_pkg::ST_NULL;
				if (find_flow(SIDE_OUT, ev.packet_id) >= 0)
					return mqfst_pkg::ST_NULL;
				slot = free_slot(SIDE_OUT);
				if (slot < 0)
					return mqfst_pkg::ST_NULL;
				flows[SIDE_OUT][slot] = '{id: ev.packet_id, qos: ev.qos,
					st: mqfst_pkg::ST_PUBLISH_SEND};
				return mqfst_pkg::ST_PUBLISH_SEND;
			end
			mqfst_pkg::KIND_PUBLISH: begin
				if (ev.packet_id == mqfst_pkg::ID_NONE)
					return mqfst_pkg::ST_DONE;
				if (ev.direction == DIR_SENT) begin
					slot = find_flow(SIDE_OUT, ev.packet_id);
					if (slot < 0 || flows[SIDE_OUT][slot].st != mqfst_pkg::ST_PUBLISH_SEND)
						return mqfst_pkg::ST_NULL;
					if (flows[SIDE_OUT][slot].qos == mqfst_pkg::QOS_1)
						nxt = mqfst_pkg::ST_PUBACK_PENDING;
					else if (flows[SIDE_OUT][slot].qos == mqfst_pkg::QOS_2)
						nxt = mqfst_pkg::ST_PUBREC_PENDING;
					else
						return mqfst_pkg::ST_NULL;
					flows[SIDE_OUT][slot].st = nxt;
					return nxt;
				end
				if (ev.qos == mqfst_pkg::QOS_1)
					nxt = mqfst_pkg::ST_PUBACK_SEND;
				else if (ev.qos == mqfst_pkg::QOS_2)
					nxt = mqfst_pkg::ST_PUBREC_SEND;
				else
					return mqfst_pkg::ST_NULL;
				if (find_flow(SIDE_IN, ev.packet_id) >= 0)
					return mqfst_pkg::ST_NULL;
				slot = free_slot(SIDE_IN);
				if (slot < 0)
					return mqfst_pkg::ST_NULL;
				flows[SIDE_IN][slot] = '{id: ev.packet_id, qos: ev.qos, st: nxt};
				return nxt;
			end
			mqfst_pkg::KIND_ACK: begin
				// PUBREL sent and the other acks received belong to outgoing flows
				if (ev.ack_type == mqfst_pkg::ACK_PUBREL)
					side = (ev.direction == DIR_SENT) ? SIDE_OUT : SIDE_IN;
				else
					side = (ev.direction == DIR_RCVD) ? SIDE_OUT : SIDE_IN;
				slot = find_flow(side, ev.packet_id);
				if (slot < 0)
					return mqfst_pkg::ST_NULL;
				want_qos = mqfst_pkg::QOS_2;
				unique case (ev.ack_type)
					mqfst_pkg::ACK_PUBACK: begin
						want_qos = mqfst_pkg::QOS_1;
						nxt = mqfst_pkg::ST_DONE;
					end
					mqfst_pkg::ACK_PUBREC:
						nxt = ev.direction ? mqfst_pkg::ST_PUBREL_SEND
						                   : mqfst_pkg::ST_PUBREL_PENDING;
					mqfst_pkg::ACK_PUBREL:
						nxt = ev.direction ? mqfst_pkg::ST_PUBCOMP_SEND
						                   : mqfst_pkg::ST_PUBCOMP_PENDING;
					default: nxt = mqfst_pkg::ST_DONE;
				endcase
				if (flows[side][slot].qos != want_qos)
					return mqfst_pkg::ST_NULL;
				// the states each target may be reached from
				unique case (nxt)
					mqfst_pkg::ST_DONE:
						legal = flows[side][slot].st inside {mqfst_pkg::ST_PUBACK_SEND,
							mqfst_pkg::ST_PUBACK_PENDING, mqfst_pkg::ST_PUBCOMP_SEND,
							mqfst_pkg::ST_PUBCOMP_PENDING};
					mqfst_pkg::ST_PUBREL_PENDING:
						legal = flows[side][slot].st == mqfst_pkg::ST_PUBREC_SEND;
					mqfst_pkg::ST_PUBCOMP_SEND:
						legal = flows[side][slot].st == mqfst_pkg::ST_PUBREL_PENDING;
					mqfst_pkg::ST_PUBREL_SEND:
						legal = flows[side][slot].st == mqfst_pkg::ST_PUBREC_PENDING;
					mqfst_pkg::ST_PUBCOMP_PENDING:
						legal = flows[side][slot].st == mqfst_pkg::ST_PUBREL_SEND;
					default: legal = 1'b0;
				endcase
				if (!legal)
					return mqfst_pkg::ST_NULL;
				if (nxt == mqfst_pkg::ST_DONE)
					flows[side][slot] = '0;
				else
					flows[side][slot].st = nxt;
				return nxt;
			end
			default: return mqfst_pkg::ST_NULL;
		endcase
	endfunction

	// ---------------------------------------------------------------- stimulus

	function automatic mqfst_pkg::item_t mk_event(input logic [1:0] kind,
			input logic [15:0] id, input logic [1:0] qos, input logic dir,
			input logic [1:0] ack);
		mqfst_pkg::item_t ev;
		ev.kind      = kind;
		ev.packet_id = id;
		ev.qos       = qos;
		ev.direction = dir;
		ev.ack_type  = ack;
		return ev;
	endfunction

	// small id pool so flows collide and tables fill; now and then any id
	function automatic logic [15:0] draw_id();
		if ($urandom_range(0, 7) == 0)
			return 16'($urandom_range(0, 16'hFFFF));
		return 16'($urandom_range(1, 24));
	endfunction

	// mostly the correct next step of a live flow, some new flows, some noise
	function automatic mqfst_pkg::item_t draw_flow_event();
		int pick;
		int side;
		mqfst_pkg::entry_t e;
		logic [1:0] qos;
		mqfst_pkg::item_t ev;
		pick = $urandom_range(0, 99);
		side = $urandom_range(0, 1);
		e = flows[side][$urandom_range(0, TABLE_DEPTH - 1)];
		if (pick < 12)
			return mk_event(2'($urandom_range(0, 3)), 16'($urandom_range(0, 16'hFFFF)),
				2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
				2'($urandom_range(0, 3)));
		if (pick < 32 || e.id == mqfst_pkg::ID_NONE) begin
			if ($urandom_range(0, 9) == 0)
				qos = 2'($urandom_range(0, 3));
			else
				qos = $urandom_range(0, 1) ? mqfst_pkg::QOS_2 : mqfst_pkg::QOS_1;
			if (side == SIDE_OUT)
				return mk_event(mqfst_pkg::KIND_RESERVE, draw_id(), qos,
					1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)));
			return mk_event(mqfst_pkg::KIND_PUBLISH, draw_id(), qos, DIR_RCVD,
				2'($urandom_range(0, 3)));
		end
		ev = mk_event(mqfst_pkg::KIND_ACK, e.id, 2'($urandom_range(0, 3)), DIR_RCVD,
			mqfst_pkg::ACK_PUBACK);
		unique case (e.st)
			mqfst_pkg::ST_PUBLISH_SEND: begin
				ev.kind = mqfst_pkg::KIND_PUBLISH;
				ev.direction = DIR_SENT;
			end
			mqfst_pkg::ST_PUBACK_PENDING:  ev.ack_type = mqfst_pkg::ACK_PUBACK;
			mqfst_pkg::ST_PUBREC_PENDING:  ev.ack_type = mqfst_pkg::ACK_PUBREC;
			mqfst_pkg::ST_PUBCOMP_PENDING: ev.ack_type = mqfst_pkg::ACK_PUBCOMP;
			mqfst_pkg::ST_PUBREL_SEND: begin
				ev.ack_type = mqfst_pkg::ACK_PUBREL;
				ev.direction = DIR_SENT;
			end
			mqfst_pkg::ST_PUBREL_PENDING:  ev.ack_type = mqfst_pkg::ACK_PUBREL;
			mqfst_pkg::ST_PUBACK_SEND: begin
				ev.ack_type = mqfst_pkg::ACK_PUBACK;
				ev.direction = DIR_SENT;
			end
			mqfst_pkg::ST_PUBREC_SEND: begin
				ev.ack_type = mqfst_pkg::ACK_PUBREC;
				ev.direction = DIR_SENT;
			end
			default: begin
				ev.ack_type = mqfst_pkg::ACK_PUBCOMP;
				ev.direction = DIR_SENT;
			end
		endcase
		// broken step: wrong ack, wrong direction or wrong kind
		if ($urandom_range(0, 9) == 0) begin
			ev.ack_type = 2'($urandom_range(0, 3));
			ev.direction = 1'($urandom_range(0, 1));
			if ($urandom_range(0, 1))
				ev.kind = 2'($urandom_range(0, 3));
		end
		return ev;
	endfunction

	// one slave transfer; prediction is taken at the accepting edge
	task automatic send_event(input mqfst_pkg::item_t ev);
		int gap;
		flow_result_t want;
		gap = tx_idle ? $urandom_range(0, 16) : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= ev.kind;
		s_tdata  <= {3'b000, ev.ack_type, ev.direction, ev.qos, ev.packet_id};
		do @(posedge clk); while (!(s_tvalid && s_tready));
		want.ev = ev;
		want.new_state = advance_flows(ev);
		pending_states.push_back(want);
		n_sent++;
	endtask

	// sender pauses until every expected result is back
	task automatic drain();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending_states.size() != 0);
	endtask

	task automatic report_mismatch(input string what);
		n_errors++;
		$display("[%0t] ERROR %s", $time, what);
	endtask

	// ---------------------------------------------------------------- tests

	task automatic test_directed();
		// QoS1 outgoing, bad reserves, publish with no id
		send_event(mk_event(mqfst_pkg::KIND_RESERVE, mqfst_pkg::ID_NONE, mqfst_pkg::QOS_1,
			DIR_SENT, mqfst_pkg::ACK_PUBACK));
		send_event(mk_event(mqfst_pkg::KIND_RESERVE, 16'hFFFF, QOS_0, DIR_SENT,
			mqfst_pkg::ACK_PUBCOMP));
		send_event(mk_event(mqfst_pkg::KIND_RESERVE, 16'hFFFF, QOS_3, DIR_RCVD,
			mqfst_pkg::ACK_PUBREL));
		send_event(mk_event(mqfst_pkg::KIND_RESERVE, 16'hFFFF, mqfst_pkg::QOS_1, DIR_SENT,
			mqfst_pkg::ACK_PUBACK));
		send_event(mk_event(mqfst_pkg::KIND_RESERVE, 16'hFFFF, mqfst_pkg::QOS_2, DIR_SENT,
			mqfst_pkg::ACK_PUBACK));
		send_event(mk_event(mqfst_pkg::KIND_PUBLISH, mqfst_pkg::ID_NONE, QOS_0, DIR_RCVD,
			mqfst_pkg::ACK_PUBACK));
		send_event(mk_event(mqfst_pkg::KIND_PUBLISH, 16'hFFFF, QOS_3, DIR_SENT,
			mqfst_pkg::ACK_PUBCOMP));
		send_event(mk_event(mqfst_pkg::KIND_PUBLISH, 16'hFFFF, mqfst_pkg::QOS_1, DIR_SENT,
			mqfst_pkg::ACK_PUBACK));
		send_event(mk_event(mqfst_pkg::KIND_ACK, 16'hFFFF, mqfst_pkg::QOS_1, DIR_RCVD,
			mqfst_pkg::ACK_PUBREC));
		send_event(mk_event(mqfst_pkg::KIND_ACK, 16'hFFFF, mqfst_pkg::QOS_1, DIR_RCVD,
			mqfst_pkg::ACK_PUBACK));
		send_event(mk_event(mqfst_pkg::KIND_ACK, 16'hFFFF, mqfst_pkg::QOS_1, DIR_RCVD,
			mqfst_pkg::ACK_PUBACK));
		// QoS2 outgoing, with an out-of-order PUBCOMP first
		send_event(mk_event(mqfst_pkg::KIND_RESERVE, 16'h0001, mqfst_pkg::QOS_2, DIR_SENT,
			mqfst_pkg::ACK_PUBACK));
		send_event(mk_event(mqfst_pkg::KIND_PUBLISH, 16'h0001, mqfst_pkg::QOS_2, DIR_SENT,
			mqfst_pkg::ACK_PUBACK));
		send_event(mk_event(mqfst_pkg::KIND_ACK, 16'h0001, mqfst_pkg::QOS_2, DIR_RCVD,
			mqfst_pkg::ACK_PUBCOMP));
		send_event(mk_event(mqfst_pkg::KIND_ACK, 16'h0001, mqfst_pkg::QOS_2, DIR_RCVD,
			mqfst_pkg::ACK_PUBREC));
		send_event(mk_event(mqfst_pkg::KIND_ACK, 16'h0001, mqfst_pkg::QOS_2, DIR_SENT,
			mqfst_pkg::ACK_PUBREL));
		send_event(mk_event(mqfst_pkg::KIND_ACK, 16'h0001, mqfst_pkg::QOS_2, DIR_RCVD,
			mqfst_pkg::ACK_PUBCOMP));
		// QoS2 incoming, duplicate publish
		send_event(mk_event(mqfst_pkg::KIND_PUBLISH, 16'h8000, mqfst_pkg::QOS_2, DIR_RCVD,
			mqfst_pkg::ACK_PUBACK));
		send_event(mk_event(mqfst_pkg::KIND_PUBLISH, 16'h8000, mqfst_pkg::QOS_2, DIR_RCVD,
			mqfst_pkg::ACK_PUBACK));
		send_event(mk_event(mqfst_pkg::KIND_ACK, 16'h8000, mqfst_pkg::QOS_2, DIR_SENT,
			mqfst_pkg::ACK_PUBREC));
		send_event(mk_event(mqfst_pkg::KIND_ACK, 16'h8000, mqfst_pkg::QOS_2, DIR_RCVD,
			mqfst_pkg::ACK_PUBREL));
		send_event(mk_event(mqfst_pkg::KIND_ACK, 16'h8000, mqfst_pkg::QOS_2, DIR_SENT,
			mqfst_pkg::ACK_PUBCOMP));
		// QoS1 incoming, bad qos on receive, ack on no id, unused kind
		send_event(mk_event(mqfst_pkg::KIND_PUBLISH, 16'h5555, mqfst_pkg::QOS_1, DIR_RCVD,
			mqfst_pkg::ACK_PUBACK));
		send_event(mk_event(mqfst_pkg::KIND_PUBLISH, 16'hAAAA, QOS_3, DIR_RCVD,
			mqfst_pkg::ACK_PUBREL));
		send_event(mk_event(mqfst_pkg::KIND_PUBLISH, 16'hAAAA, QOS_0, DIR_RCVD,
			mqfst_pkg::ACK_PUBACK));
		send_event(mk_event(mqfst_pkg::KIND_ACK, 16'h5555, mqfst_pkg::QOS_1, DIR_SENT,
			mqfst_pkg::ACK_PUBACK));
		send_event(mk_event(mqfst_pkg::KIND_ACK, mqfst_pkg::ID_NONE, mqfst_pkg::QOS_1,
			DIR_SENT, mqfst_pkg::ACK_PUBACK));
		send_event(mk_event(KIND_UNUSED, 16'h1234, mqfst_pkg::QOS_2, DIR_RCVD,
			mqfst_pkg::ACK_PUBCOMP));
	endtask

	// both tables to capacity, one extra open on each is refused
	task automatic test_table_full();
		for (int i = 0; i <= TABLE_DEPTH; i++)
			send_event(mk_event(mqfst_pkg::KIND_RESERVE, 16'h1000 + 16'(i),
				(i % 2) ? mqfst_pkg::QOS_2 : mqfst_pkg::QOS_1, DIR_SENT,
				mqfst_pkg::ACK_PUBACK));
		for (int i = 0; i <= TABLE_DEPTH; i++)
			send_event(mk_event(mqfst_pkg::KIND_PUBLISH, 16'h2000 + 16'(i),
				(i % 2) ? mqfst_pkg::QOS_2 : mqfst_pkg::QOS_1, DIR_RCVD,
				mqfst_pkg::ACK_PUBACK));
	endtask

	task automatic test_random_flows(input int count);
		repeat (count) send_event(draw_flow_event());
	endtask

	task automatic test_back_to_back();
		tx_idle = 1'b0;
		rx_idle = 1'b0;
		repeat (40) send_event(draw_flow_event());
		tx_idle = 1'b1;
		rx_idle = 1'b1;
	endtask

	// receiver holds off while events keep coming, so the input stalls
	task automatic test_backpressure();
		drain();
		rx_hold_cycles = 300;
		tx_idle = 1'b0;
		repeat (12) send_event(draw_flow_event());
		tx_idle = 1'b1;
		drain();
	endtask

	// ---------------------------------------------------------------- processes

	// result sink: random wait per result, or one long hold on request
	initial begin : result_sink
		int wait_n;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (rx_hold_cycles > 0) begin
				wait_n = rx_hold_cycles;
				rx_hold_cycles = 0;
			end else begin
				wait_n = rx_idle ? $urandom_range(0, 16) : 0;
			end
			if (wait_n > 0) begin
				m_tready <= 1'b0;
				repeat (wait_n) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!(m_tvalid && m_tready));
		end
	end

	always @(posedge clk) begin
		flow_result_t want;
		if (m_tvalid && m_tready) begin
			n_results++;
			if (pending_states.size() == 0) begin
				report_mismatch($sformatf("result state %0d with nothing pending",
					m_tdata[3:0]));
			end else begin
				want = pending_states.pop_front();
				if (want.new_state == mqfst_pkg::ST_DONE)
					n_done++;
				if (want.new_state == mqfst_pkg::ST_NULL)
					n_null++;
				if (m_tdata[3:0] !== want.new_state)
					report_mismatch($sformatf(
						"kind %0d id %04h qos %0d dir %0d ack %0d: state %0d, want %0d",
						want.ev.kind, want.ev.packet_id, want.ev.qos, want.ev.direction,
						want.ev.ack_type, m_tdata[3:0], want.new_state));
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("timeout: no transfer for %0d cycles", IDLE_LIMIT);
				$display("mqtt_qos_flow_state_table: mismatch");
				$finish;
			end
		end
	end

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_table_full();
		test_random_flows(320);
		test_back_to_back();
		test_backpressure();

		drain();
		repeat (TABLE_DEPTH + 8) @(posedge clk);

		$display("%0d events sent, %0d results checked: %0d flows closed, %0d refused",
			n_sent, n_results, n_done, n_null);
		$display("covered full tables, broken handshakes, back-to-back and a long stall");
		if (n_errors == 0)
			$display("mqtt_qos_flow_state_table: match");
		else
			$display("mqtt_qos_flow_state_table: mismatch");
		$finish;
	end

endmodule

// ===== mqtt_qos_flow_state_table.f =====
src/mqfst_pkg.sv
src/mqfst_ctrl.sv
src/mqfst_dp.sv
src/mqtt_qos_flow_state_table.sv
tb/mqtt_qos_flow_state_table_tb.sv
